// File: rtl/core/base64_encoder_with_group_spacing_defines.svh
// ----------------------------------------------------------------------------
// Base64 encoder with group spacing: assertion macros
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef BASE64_ENCODER_WITH_GROUP_SPACING_DEFINES_SVH
`define BASE64_ENCODER_WITH_GROUP_SPACING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B64GS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64GS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/b64gs_pkg.sv
// ----------------------------------------------------------------------------
// b64gs_pkg
// Types, character constants and the sextet-to-ASCII map for the encoder.
// ----------------------------------------------------------------------------
package b64gs_pkg;

  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned MAX_CHARS   = 5;
  localparam int unsigned CNT_W       = 3;

  localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'h3D;  // '='
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;  // ' '
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;  // '/'

  localparam logic [7:0] GPS_RESET = 8'd14;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_GROUP       = 3'd4;
  localparam logic [CNT_W-1:0] CNT_GROUP_SPACE = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } src_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
  } res_item_t;

  // One group of characters handed from the encoder to the serializer.
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;  // chars[0] goes out first
    logic [CNT_W-1:0]                 count;  // 0 when the item emits nothing
    logic                             last;   // last char closes the message
  } group_t;

  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/base64_encoder_with_group_spacing.sv
// ----------------------------------------------------------------------------
// base64_encoder_with_group_spacing
// Byte-stream base64 encoder that inserts a space after every N groups.
// ----------------------------------------------------------------------------
// Usage:
//   src channel: one byte per item with an end-of-message flag. An item is
//   taken at a clock edge with src_valid high and src_stall low.
//   res channel: one ASCII character per item; last_char marks the final
//   character of a message's encoding. Taken with res_valid high and
//   res_stall low.
//   cfg channel: write groups_per_space (0 turns spaces off); cfg_ready is
//   always high. Write only while the block is idle.
// The byte that completes a group loads the group buffer at the edge that
//   takes it; the first character then moves from the group buffer into
//   the output register, from which the receiver takes it.
// Throughput: one character per cycle out of the output register while
//   res_stall is low; a group is 4 characters, 5 with a space. src_stall
//   holds every byte, including those that only fill the pending store,
//   while the group buffer is busy, so no new byte is taken until the
//   group's last character leaves the buffer.
// Reset: pending bytes and space count clear, groups_per_space returns to
//   14, nothing is in flight.
// A stalled receiver holds the output item; the group buffer then stays
//   busy and src_stall stays high until characters drain again.
// ----------------------------------------------------------------------------
module base64_encoder_with_group_spacing (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  b64gs_pkg::src_item_t  src_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output b64gs_pkg::res_item_t  res_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);
  import b64gs_pkg::*;

  logic [7:0] groups_per_space;
  group_t     grp;
  logic       accept;
  logic       load;
  logic       full;

  // Accept a byte whenever the group buffer is free or drains this cycle.
  assign src_stall = full;
  assign accept    = src_valid && !src_stall;
  // Hand a group on only when the item produced characters.
  assign load      = accept && (grp.count != '0);
  assign cfg_ready = 1'b1;

  // Hold the spacing register; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_space <= GPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      groups_per_space <= cfg_data;
    end
  end

  b64gs_encode u_encode (
    .clk              (clk),
    .rst              (rst),
    .item             (src_item),
    .accept           (accept),
    .groups_per_space (groups_per_space),
    .grp              (grp)
  );

  b64gs_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .load      (load),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// File: rtl/core/b64gs_encode.sv
// ----------------------------------------------------------------------------
// b64gs_encode
// Holds pending bytes and the space counter; forms one character group.
// ----------------------------------------------------------------------------
`include "base64_encoder_with_group_spacing_defines.svh"

module b64gs_encode (
  input  logic                  clk,
  input  logic                  rst,
  input  b64gs_pkg::src_item_t  item,
  input  logic                  accept,
  input  logic [7:0]            groups_per_space,
  output b64gs_pkg::group_t     grp
);
  import b64gs_pkg::*;

  logic [15:0] pending_bytes, pending_bytes_next;
  logic [1:0]  pending_count, pending_count_next;
  logic [7:0]  groups_since_space, groups_since_space_next;

  logic [1:0]  cnt;
  logic [23:0] w;
  logic [7:0]  gss_inc;
  logic        space_due;

  always_comb begin
    cnt = (pending_count == 2'd3) ? PEND_NONE : pending_count;
    gss_inc = groups_since_space + 8'd1;
    space_due = (groups_per_space != 8'd0) && (gss_inc >= groups_per_space);

    unique case (cnt)
      PEND_TWO: w = {pending_bytes, item.data_byte};
      PEND_ONE: w = {pending_bytes[7:0], item.data_byte, 8'h00};
      default:  w = {item.data_byte, 16'h0000};
    endcase

    grp.chars[0] = b64_char(w[23:18]);
    grp.chars[1] = b64_char(w[17:12]);
    grp.chars[2] = b64_char(w[11:6]);
    grp.chars[3] = b64_char(w[5:0]);
    grp.chars[4] = CHAR_SPACE;
    grp.last     = item.end_of_message;

    pending_bytes_next      = pending_bytes;
    pending_count_next      = pending_count;
    groups_since_space_next = groups_since_space;

    if (cnt == PEND_TWO) begin
      grp.count          = space_due ? CNT_GROUP_SPACE : CNT_GROUP;
      pending_bytes_next = 16'h0000;
      pending_count_next = PEND_NONE;
      if (groups_per_space != 8'd0) begin
        groups_since_space_next = space_due ? 8'd0 : gss_inc;
      end
    end else if (!item.end_of_message) begin
      grp.count          = '0;
      pending_bytes_next = {(cnt == PEND_ONE) ? pending_bytes[7:0] : 8'h00, item.data_byte};
      pending_count_next = cnt + 2'd1;
    end else begin
      grp.count = CNT_GROUP;
      if (cnt != PEND_ONE) begin
        grp.chars[2] = CHAR_PAD;
      end
      grp.chars[3] = CHAR_PAD;
    end

    // End of message: start the next one from a clean state.
    if (item.end_of_message) begin
      pending_bytes_next      = 16'h0000;
      pending_count_next      = PEND_NONE;
      groups_since_space_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes      <= 16'h0000;
      pending_count      <= PEND_NONE;
      groups_since_space <= 8'd0;
    end else if (accept) begin
      pending_bytes      <= pending_bytes_next;
      pending_count      <= pending_count_next;
      groups_since_space <= groups_since_space_next;
    end
  end

  `B64GS_ASSERT_NOW(a_pend_range, clk, rst, 1'b1, pending_count != 2'd3, "pending count out of range")
  `B64GS_ASSERT_NEXT(a_eom_clear, clk, rst, accept && item.end_of_message, pending_count == PEND_NONE && groups_since_space == 8'd0, "state not cleared after end of message")
  `B64GS_ASSERT_NOW(a_grp_count, clk, rst, 1'b1, grp.count == 3'd0 || grp.count == CNT_GROUP || grp.count == CNT_GROUP_SPACE, "bad group size")

endmodule

// File: rtl/core/b64gs_serial.sv
// ----------------------------------------------------------------------------
// b64gs_serial
// Group buffer and output register; sends one character per cycle unless res_stall holds the output.
// ----------------------------------------------------------------------------
`include "base64_encoder_with_group_spacing_defines.svh"

module b64gs_serial (
  input  logic                  clk,
  input  logic                  rst,
  input  b64gs_pkg::group_t     grp,
  input  logic                  load,
  output logic                  full,
  output logic                  res_valid,
  input  logic                  res_stall,
  output b64gs_pkg::res_item_t  res_item
);
  import b64gs_pkg::*;

  logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
  logic [CNT_W-1:0]                 remaining;
  logic                             last;

  logic out_adv;
  logic pop;
  logic pop_last;

  assign out_adv  = !res_valid || !res_stall;
  assign pop      = (remaining != '0) && out_adv;
  assign pop_last = pop && (remaining == 3'd1);
  // Busy while a group is buffered, unless it drains this cycle.
  assign full     = (remaining != '0) && !pop_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        remaining <= grp.count;
      end else if (pop) begin
        remaining <= remaining - 3'd1;
      end
      if (out_adv) begin
        res_valid <= remaining != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= grp.chars;
      last  <= grp.last;
    end else if (pop) begin
      chars <= {CHAR_SPACE, chars[MAX_CHARS-1:1]};
    end
    if (pop) begin
      res_item.out_char  <= chars[0];
      res_item.last_char <= last && (remaining == 3'd1);
    end
  end

  `B64GS_ASSERT_NOW(a_load_free, clk, rst, load, remaining == 3'd0 || pop_last, "group loaded over a busy buffer")
  `B64GS_ASSERT_NOW(a_rem_range, clk, rst, 1'b1, remaining <= 3'd5, "group count out of range")
  `B64GS_ASSERT_NEXT(a_pop_out, clk, rst, pop, res_valid, "popped char not presented")

endmodule
